FILE: design/tcvg_pkg.sv
// Shared widths, register indexes and pipeline types for the torus cell
// vertex generator. No dependencies; imported by every design file.

package tcvg_pkg;

  // Field widths
  localparam int IDX_W     = 8;
  localparam int RAD_W     = 16;
  localparam int OUT_W     = 18;
  localparam int CORNER_W  = 3;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MINOR_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAJOR_RADIUS = 2'd1;

  // Register reset values, unsigned Q8.8
  localparam logic [RAD_W-1:0] MINOR_RADIUS_RST = 16'd256;
  localparam logic [RAD_W-1:0] MAJOR_RADIUS_RST = 16'd512;

  // Corner sequencing: corners 0..5, the last one closes the cell
  localparam logic [CORNER_W-1:0] LAST_CORNER = 3'd5;
  // Corners that take the next section step (2, 3, 5) or next segment step (1, 4, 5)
  localparam logic [5:0] NEXT_SEC_MASK = 6'b101100;
  localparam logic [5:0] NEXT_SEG_MASK = 6'b110010;

  // Control that travels with each corner down the pipeline
  typedef struct packed {
    logic                valid;
    logic [CORNER_W-1:0] corner;
    logic                last;
    logic                bad;
  } meta_t;

endpackage

FILE: design/torus_cell_vertex_generator_top.sv
// Torus cell vertex generator: one mesh cell in, six triangle corners out.
// Depends on tcvg_pkg and tcvg_trig_rom.
//
// Usage:
//   Input: a cell (section_index, segment_index) is taken at a clock edge
//   with start high and busy low. A valid cell yields six corner results on
//   consecutive cycles, marked by result_valid, corner 0..5, last_corner
//   on corner 5. An index out of range yields one result with bad_index and
//   last_corner set and all other fields zero.
//   Configuration: cfg_valid/cfg_ready write minor_radius (index 0) or
//   major_radius (index 1); other indexes are ignored. cfg_ready is always
//   high. Write only while no results are pending.
//   Throughput: one corner per cycle; a valid cell holds the sequencer
//   for its six corners, a bad cell for its one. busy drops in the cycle
//   the last corner issues, so cells follow back to back.
//   Pipeline: sequencer, table read, r*trig, round and add R, four products,
//   round to outputs. Each result is valid for exactly one cycle; the
//   receiver cannot stall, so nothing is held back.
//   Reset: synchronous rst clears the sequencer and pipeline valids and
//   restores the radii to 1.0 and 2.0.

module torus_cell_vertex_generator_top #(
  parameter int SEGMENTS  = 40,
  parameter int SECTIONS  = 30,
  parameter int TRIG_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [tcvg_pkg::IDX_W-1:0]          section_index,
  input  logic [tcvg_pkg::IDX_W-1:0]          segment_index,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tcvg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcvg_pkg::RAD_W-1:0]          cfg_data,
  output logic                                result_valid,
  output logic signed [tcvg_pkg::OUT_W-1:0]   pos_x,
  output logic signed [tcvg_pkg::OUT_W-1:0]   pos_y,
  output logic signed [tcvg_pkg::OUT_W-1:0]   pos_z,
  output logic signed [tcvg_pkg::OUT_W-1:0]   norm_x,
  output logic signed [tcvg_pkg::OUT_W-1:0]   norm_y,
  output logic signed [tcvg_pkg::OUT_W-1:0]   norm_z,
  output logic [tcvg_pkg::CORNER_W-1:0]       corner,
  output logic                                last_corner,
  output logic                                bad_index
);
  import tcvg_pkg::*;

  localparam int TW   = TRIG_BITS + 2;     // trig value, sign plus 1.TB
  localparam int RW   = RAD_W + 1;         // radius as a signed operand
  localparam int SW   = OUT_W + 1;         // R + r*cos a
  localparam int PA_W = RW + TW;           // r * trig
  localparam int PS_W = SW + TW;           // (R + rc) * trig
  localparam int PR_W = OUT_W + TW;        // rc * trig
  localparam logic [IDX_W:0] SEC_N = (IDX_W + 1)'(SECTIONS);
  localparam logic [IDX_W:0] SEG_N = (IDX_W + 1)'(SEGMENTS);
  localparam logic [PS_W-1:0] HALF = PS_W'(1) << (TRIG_BITS - 1);

  // Round away TRIG_BITS fraction bits, to nearest, ties away from zero
  function automatic logic signed [OUT_W-1:0] rnd(logic signed [PS_W-1:0] v);
    logic [PS_W-1:0]         mag;
    logic [PS_W-1:0]         q;
    logic signed [OUT_W-1:0] res;
    mag = v[PS_W-1] ? $unsigned(-v) : $unsigned(v);
    q   = (mag + HALF) >> TRIG_BITS;
    res = $signed(q[OUT_W-1:0]);
    if (v[PS_W-1]) begin
      res = -res;
    end
    return res;
  endfunction

  // Configuration registers
  logic [RAD_W-1:0] minor_radius;
  logic [RAD_W-1:0] major_radius;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      minor_radius <= MINOR_RADIUS_RST;
      major_radius <= MAJOR_RADIUS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MINOR_RADIUS: minor_radius <= cfg_data;
        CFG_MAJOR_RADIUS: major_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  // Corner sequencer
  logic                seq_active;
  logic [CORNER_W-1:0] seq_cnt;
  logic                seq_bad;
  logic [IDX_W-1:0]    sec_a, sec_a1, seg_b, seg_b1;
  logic                accept;
  logic                in_bad;
  logic                seq_last;

  assign seq_last = (seq_cnt == LAST_CORNER);
  assign busy     = seq_active && !seq_last;
  assign accept   = start && !busy;
  assign in_bad   = ({1'b0, section_index} >= SEC_N) || ({1'b0, segment_index} >= SEG_N);

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_active <= 1'b0;
      seq_cnt    <= '0;
      seq_bad    <= 1'b0;
    end else if (accept) begin
      seq_active <= 1'b1;
      seq_cnt    <= in_bad ? LAST_CORNER : '0;
      seq_bad    <= in_bad;
    end else if (seq_active) begin
      if (seq_last) begin
        seq_active <= 1'b0;
      end else begin
        seq_cnt <= seq_cnt + 1'b1;
      end
    end
  end

  // Cell indexes and their wrapped successors
  always_ff @(posedge clk) begin
    if (accept) begin
      sec_a  <= section_index;
      seg_b  <= segment_index;
      sec_a1 <= ({1'b0, section_index} + 1'b1 == SEC_N) ? '0 : section_index + 1'b1;
      seg_b1 <= ({1'b0, segment_index} + 1'b1 == SEG_N) ? '0 : segment_index + 1'b1;
    end
  end

  // Table addresses for the issuing corner
  logic [IDX_W-1:0] sec_idx, seg_idx;

  assign sec_idx = NEXT_SEC_MASK[seq_cnt] ? sec_a1 : sec_a;
  assign seg_idx = NEXT_SEG_MASK[seq_cnt] ? seg_b1 : seg_b;

  // Stage 1: table read
  logic signed [TW-1:0] sa1, ca1, sb1, cb1;
  meta_t                m1;

  tcvg_trig_rom #(.N(SECTIONS), .TB(TRIG_BITS)) u_sec_rom (
    .clk   (clk),
    .idx   (sec_idx),
    .sin_q (sa1),
    .cos_q (ca1)
  );

  tcvg_trig_rom #(.N(SEGMENTS), .TB(TRIG_BITS)) u_seg_rom (
    .clk   (clk),
    .idx   (seg_idx),
    .sin_q (sb1),
    .cos_q (cb1)
  );

  // Stage 2: r*cos a, r*sin a
  logic signed [RW-1:0]   r_s;
  logic signed [PA_W-1:0] p_rca2, p_rsa2;
  logic signed [TW-1:0]   sb2, cb2;
  meta_t                  m2;

  assign r_s = $signed({1'b0, minor_radius});

  always_ff @(posedge clk) begin
    p_rca2 <= r_s * ca1;
    p_rsa2 <= r_s * sa1;
    sb2    <= sb1;
    cb2    <= cb1;
  end

  // Stage 3: round, then R + rc
  logic signed [OUT_W-1:0] rc_rnd;
  logic signed [OUT_W-1:0] rc3, sy3;
  logic signed [SW-1:0]    s3;
  logic signed [TW-1:0]    sb3, cb3;
  meta_t                   m3;

  assign rc_rnd = rnd(PS_W'(p_rca2));

  always_ff @(posedge clk) begin
    rc3 <= rc_rnd;
    sy3 <= rnd(PS_W'(p_rsa2));
    s3  <= $signed({{(SW - RAD_W){1'b0}}, major_radius}) + SW'(rc_rnd);
    sb3 <= sb2;
    cb3 <= cb2;
  end

  // Stage 4: ring products
  logic signed [PS_W-1:0]  p_sc4, p_ss4;
  logic signed [PR_W-1:0]  p_rc4, p_rs4;
  logic signed [OUT_W-1:0] sy4;
  meta_t                   m4;

  always_ff @(posedge clk) begin
    p_sc4 <= s3 * cb3;
    p_ss4 <= s3 * sb3;
    p_rc4 <= rc3 * cb3;
    p_rs4 <= rc3 * sb3;
    sy4   <= sy3;
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      m1 <= '0;
      m2 <= '0;
      m3 <= '0;
      m4 <= '0;
    end else begin
      m1 <= '{valid: seq_active, corner: seq_cnt, last: seq_last, bad: seq_bad};
      m2 <= m1;
      m3 <= m2;
      m4 <= m3;
    end
  end

  // Stage 5: output registers; a bad cell reports zeros
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= m4.valid;
    end
  end

  always_ff @(posedge clk) begin
    last_corner <= m4.last;
    bad_index   <= m4.bad;
    if (m4.bad) begin
      pos_x  <= '0;
      pos_y  <= '0;
      pos_z  <= '0;
      norm_x <= '0;
      norm_y <= '0;
      norm_z <= '0;
      corner <= '0;
    end else begin
      pos_x  <= rnd(p_sc4);
      pos_y  <= sy4;
      pos_z  <= rnd(p_ss4);
      norm_x <= rnd(PS_W'(p_rc4));
      norm_y <= sy4;
      norm_z <= rnd(PS_W'(p_rs4));
      corner <= m4.corner;
    end
  end

endmodule

FILE: design/tcvg_trig_rom.sv
// Sine/cosine table for one angle axis: N steps per turn, TB fraction bits,
// built at elaboration, read with a registered port. Depends on tcvg_pkg.

module tcvg_trig_rom #(
  parameter int N  = 30,
  parameter int TB = 16
) (
  input  logic                        clk,
  input  logic [tcvg_pkg::IDX_W-1:0]  idx,
  output logic signed [TB+1:0]        sin_q,
  output logic signed [TB+1:0]        cos_q
);
  import tcvg_pkg::*;

  localparam int AW = $clog2(N);
  localparam int TW = TB + 2;
  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Restoring division, evaluated at elaboration only
  function automatic longint unsigned udiv(longint unsigned a, longint unsigned b);
    longint unsigned q;
    longint unsigned rem;
    q   = 0;
    rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], a[i]};
      if (rem >= b) begin
        rem  = rem - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Series divisors for sine (six terms) and cosine (seven terms)
  function automatic longint unsigned coef(bit is_cos, int i);
    longint unsigned d;
    d = 1;
    if (is_cos) begin
      case (i)
        0: d = 182;
        1: d = 132;
        2: d = 90;
        3: d = 56;
        4: d = 30;
        5: d = 12;
        default: d = 2;
      endcase
    end else begin
      case (i)
        0: d = 156;
        1: d = 110;
        2: d = 72;
        3: d = 42;
        4: d = 20;
        default: d = 6;
      endcase
    end
    return d;
  endfunction

  // Truncated Horner evaluation in Q2.30, clamped at zero
  function automatic longint unsigned horner(longint unsigned x2, bit is_cos);
    longint unsigned t;
    longint unsigned p;
    int n;
    t = Q30_ONE;
    n = is_cos ? 7 : 6;
    for (int i = 0; i < n; i++) begin
      p = udiv((x2 * t) >> 30, coef(is_cos, i));
      t = (p > Q30_ONE) ? 64'd0 : Q30_ONE - p;
    end
    return t;
  endfunction

  // sin or cos of k/n of a turn, tb fraction bits, signed
  function automatic longint signed trig_val(int k, int n, int tb, bit want_cos);
    longint unsigned q;
    longint unsigned rest;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned sv;
    longint unsigned cv;
    longint signed   res;
    q    = udiv(64'(4 * k), 64'(n));
    rest = 64'(4 * k) - q * 64'(n);
    x    = udiv(rest * HALF_PI_Q30, 64'(n));
    x2   = (x * x) >> 30;
    sv   = (((x * horner(x2, 1'b0)) >> 30) + (64'd1 << (29 - tb))) >> (30 - tb);
    cv   = (horner(x2, 1'b1) + (64'd1 << (29 - tb))) >> (30 - tb);
    case (q[1:0])
      2'd0:    res = want_cos ?  $signed(cv) :  $signed(sv);
      2'd1:    res = want_cos ? -$signed(sv) :  $signed(cv);
      2'd2:    res = want_cos ? -$signed(cv) : -$signed(sv);
      default: res = want_cos ?  $signed(sv) : -$signed(cv);
    endcase
    return res;
  endfunction

  logic signed [TW-1:0] sin_tab [2**AW];
  logic signed [TW-1:0] cos_tab [2**AW];

  // Constant table; unused tail entries read as zero
  for (genvar k = 0; k < 2**AW; k++) begin : g_tab
    localparam longint SV = (k < N) ? trig_val(k, N, TB, 1'b0) : 64'sd0;
    localparam longint CV = (k < N) ? trig_val(k, N, TB, 1'b1) : 64'sd0;
    assign sin_tab[k] = SV[TW-1:0];
    assign cos_tab[k] = CV[TW-1:0];
  end

  // Registered read
  always_ff @(posedge clk) begin
    sin_q <= sin_tab[idx[AW-1:0]];
    cos_q <= cos_tab[idx[AW-1:0]];
  end

endmodule

FILE: design/tcvg_checker.sv
// Port-level checks for the torus cell vertex generator, bound to the top.
// Depends on tcvg_pkg and torus_cell_vertex_generator_top.

module tcvg_assertions (
  input logic                               clk,
  input logic                               rst,
  input logic                               result_valid,
  input logic [tcvg_pkg::CORNER_W-1:0]      corner,
  input logic                               last_corner,
  input logic                               bad_index,
  input logic signed [tcvg_pkg::OUT_W-1:0]  pos_x,
  input logic signed [tcvg_pkg::OUT_W-1:0]  norm_x
);
  import tcvg_pkg::*;

  // Nothing comes out right after reset
  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result transaction right after reset");

  // Corners of one cell come out on consecutive cycles
  a_corner_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_corner |=>
      result_valid && (corner == $past(corner) + 1'b1))
    else $error("corner sequence broken");

  // Last flag only on corner 5 or on a bad-index transaction
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_corner |-> bad_index || (corner == LAST_CORNER))
    else $error("last_corner on wrong corner");

  // Bad-index transaction is a single zeroed result
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && bad_index |-> last_corner && (pos_x == '0) && (norm_x == '0))
    else $error("bad_index transaction not zeroed");

endmodule

bind torus_cell_vertex_generator_top tcvg_assertions u_tcvg_assertions (.*);

FILE: dv/tcvg_checker.sv
// Scoreboard for the torus cell vertex generator: tracks the radius registers,
// predicts the corners of every accepted cell and checks each result strobe.
// Depends on tcvg_pkg; instantiated by the testbench top next to the block.
`timescale 1ns / 100ps

module tcvg_checker #(
  parameter int SEGMENTS  = 40,
  parameter int SECTIONS  = 30,
  parameter int TRIG_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic [tcvg_pkg::IDX_W-1:0]          section_index,
  input  logic [tcvg_pkg::IDX_W-1:0]          segment_index,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [tcvg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcvg_pkg::RAD_W-1:0]          cfg_data,
  input  logic                                result_valid,
  input  logic signed [tcvg_pkg::OUT_W-1:0]   pos_x,
  input  logic signed [tcvg_pkg::OUT_W-1:0]   pos_y,
  input  logic signed [tcvg_pkg::OUT_W-1:0]   pos_z,
  input  logic signed [tcvg_pkg::OUT_W-1:0]   norm_x,
  input  logic signed [tcvg_pkg::OUT_W-1:0]   norm_y,
  input  logic signed [tcvg_pkg::OUT_W-1:0]   norm_z,
  input  logic [tcvg_pkg::CORNER_W-1:0]       corner,
  input  logic                                last_corner,
  input  logic                                bad_index,
  output int                                  errors,
  output int                                  pending
);
  import tcvg_pkg::*;

  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int              FRAC_DROP   = 30 - TRIG_BITS;
  localparam int              MAX_REPORTS = 10;

  typedef struct packed {
    logic [OUT_W-1:0]    pos_x;
    logic [OUT_W-1:0]    pos_y;
    logic [OUT_W-1:0]    pos_z;
    logic [OUT_W-1:0]    norm_x;
    logic [OUT_W-1:0]    norm_y;
    logic [OUT_W-1:0]    norm_z;
    logic [CORNER_W-1:0] corner;
    logic                last;
    logic                bad;
  } vertex_t;

  typedef struct packed {
    longint sin_v;
    longint cos_v;
  } sin_cos_t;

  vertex_t          vertex_q[$];
  logic [RAD_W-1:0] minor_r;
  logic [RAD_W-1:0] major_r;
  int               err_cnt = 0;

  // Horner evaluation of the truncated Taylor series in Q2.30.
  // Divisors are j*(j+1), j running down by two: 12..2 for sine, 13..1 for cosine.
  function automatic longint unsigned taylor(longint unsigned x2, bit is_cos);
    longint unsigned term;
    longint unsigned prod;
    longint unsigned j;
    int              n_terms;
    term    = Q30_ONE;
    n_terms = is_cos ? 7 : 6;
    for (int i = 0; i < n_terms; i++) begin
      j    = (is_cos ? 13 : 12) - 2 * i;
      prod = ((x2 * term) >> 30) / (j * (j + 1));
      term = (prod > Q30_ONE) ? 64'd0 : Q30_ONE - prod;
    end
    return term;
  endfunction

  // Q2.30 down to TRIG_BITS fraction bits, half up
  function automatic longint q30_to_trig(longint unsigned v);
    return longint'((v + (64'd1 << (FRAC_DROP - 1))) >> FRAC_DROP);
  endfunction

  // Sine and cosine of step/steps of a full turn
  function automatic sin_cos_t turn_sin_cos(longint unsigned step, longint unsigned steps);
    sin_cos_t        sc;
    longint unsigned quad;
    longint unsigned rest;
    longint unsigned x;
    longint unsigned x2;
    longint          sv;
    longint          cv;
    quad = (4 * step) / steps;
    rest = 4 * step - quad * steps;
    x    = (rest * HALF_PI_Q30) / steps;
    x2   = (x * x) >> 30;
    sv   = q30_to_trig((x * taylor(x2, 1'b0)) >> 30);
    cv   = q30_to_trig(taylor(x2, 1'b1));
    case (quad % 4)
      0: begin
        sc.sin_v = sv;
        sc.cos_v = cv;
      end
      1: begin
        sc.sin_v = cv;
        sc.cos_v = -sv;
      end
      2: begin
        sc.sin_v = -sv;
        sc.cos_v = -cv;
      end
      default: begin
        sc.sin_v = -cv;
        sc.cos_v = sv;
      end
    endcase
    return sc;
  endfunction

  // Drop TRIG_BITS fraction bits, to nearest, ties away from zero
  function automatic longint drop_trig_frac(longint v);
    longint half;
    half = longint'(1) << (TRIG_BITS - 1);
    if (v >= 0)
      return (v + half) >>> TRIG_BITS;
    return -((-v + half) >>> TRIG_BITS);
  endfunction

  function automatic vertex_t corner_vertex(int sec, int seg, int k);
    vertex_t  v;
    sin_cos_t ta;
    sin_cos_t tb;
    longint   rc;
    longint   ring;
    longint   tmp;
    ta   = turn_sin_cos(sec, SECTIONS);
    tb   = turn_sin_cos(seg, SEGMENTS);
    rc   = drop_trig_frac(longint'(minor_r) * ta.cos_v);
    ring = longint'(major_r) + rc;
    tmp  = drop_trig_frac(ring * tb.cos_v);
    v.pos_x  = tmp[OUT_W-1:0];
    tmp  = drop_trig_frac(longint'(minor_r) * ta.sin_v);
    v.pos_y  = tmp[OUT_W-1:0];
    v.norm_y = tmp[OUT_W-1:0];
    tmp  = drop_trig_frac(ring * tb.sin_v);
    v.pos_z  = tmp[OUT_W-1:0];
    tmp  = drop_trig_frac(rc * tb.cos_v);
    v.norm_x = tmp[OUT_W-1:0];
    tmp  = drop_trig_frac(rc * tb.sin_v);
    v.norm_z = tmp[OUT_W-1:0];
    v.corner = k[CORNER_W-1:0];
    v.last   = (k[CORNER_W-1:0] == LAST_CORNER);
    v.bad    = 1'b0;
    return v;
  endfunction

  // Queue the six corners of a cell, or the single bad-index result
  function automatic void queue_cell_corners(int sec, int seg);
    vertex_t bad_v;
    int      sec_n;
    int      seg_n;
    if (sec >= SECTIONS || seg >= SEGMENTS) begin
      bad_v      = '0;
      bad_v.last = 1'b1;
      bad_v.bad  = 1'b1;
      vertex_q.push_back(bad_v);
      return;
    end
    sec_n = (sec + 1 == SECTIONS) ? 0 : sec + 1;
    seg_n = (seg + 1 == SEGMENTS) ? 0 : seg + 1;
    vertex_q.push_back(corner_vertex(sec,   seg,   0));
    vertex_q.push_back(corner_vertex(sec,   seg_n, 1));
    vertex_q.push_back(corner_vertex(sec_n, seg,   2));
    vertex_q.push_back(corner_vertex(sec_n, seg,   3));
    vertex_q.push_back(corner_vertex(sec,   seg_n, 4));
    vertex_q.push_back(corner_vertex(sec_n, seg_n, 5));
  endfunction

  // Sample every channel at the clock edge; results first, they belong to older cells
  always @(posedge clk) begin : monitor
    vertex_t got;
    vertex_t want;
    if (rst) begin
      minor_r = MINOR_RADIUS_RST;
      major_r = MAJOR_RADIUS_RST;
      vertex_q.delete();
    end else begin
      if (result_valid) begin
        got = '{pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, corner, last_corner, bad_index};
        if (vertex_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: unexpected result transaction, corner %0d", $realtime, corner);
        end else begin
          want = vertex_q.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display({"%0t: mismatch exp pos %0d %0d %0d norm %0d %0d %0d c %0d l %0d b %0d",
                        " / got pos %0d %0d %0d norm %0d %0d %0d c %0d l %0d b %0d"},
                       $realtime,
                       $signed(want.pos_x), $signed(want.pos_y), $signed(want.pos_z),
                       $signed(want.norm_x), $signed(want.norm_y), $signed(want.norm_z),
                       want.corner, want.last, want.bad,
                       pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                       corner, last_corner, bad_index);
          end
        end
      end
      // register writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MINOR_RADIUS: minor_r = cfg_data;
          CFG_MAJOR_RADIUS: major_r = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy)
        queue_cell_corners(section_index, segment_index);
    end
    errors  <= err_cnt;
    pending <= vertex_q.size();
  end

endmodule

FILE: dv/testbench.sv
// Top of the torus cell vertex generator testbench: clock, reset, cell and
// register stimulus, watchdog and verdict. Depends on tcvg_pkg, the block and tcvg_checker.
`timescale 1ns / 100ps

module testbench;
  import tcvg_pkg::*;

  localparam int SEGMENTS     = 40;
  localparam int SECTIONS     = 30;
  localparam int TRIG_BITS    = 16;
  localparam int STALL_LIMIT  = 2000;
  localparam int NUM_PHASES   = 6;
  localparam int CELLS_PER_PH = 24;
  localparam int SETTLE_CYC   = 10;

  logic                   clk;
  logic                   rst           = 1'b1;
  logic                   start         = 1'b0;
  logic [IDX_W-1:0]       section_index = '0;
  logic [IDX_W-1:0]       segment_index = '0;
  logic                   cfg_valid     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index     = '0;
  logic [RAD_W-1:0]       cfg_data      = '0;

  logic                   busy;
  logic                   cfg_ready;
  logic                   result_valid;
  logic signed [OUT_W-1:0] pos_x, pos_y, pos_z, norm_x, norm_y, norm_z;
  logic [CORNER_W-1:0]    corner;
  logic                   last_corner;
  logic                   bad_index;

  int errors;
  int pending;
  bit idle_en = 1'b1;
  int quiet_cycles;

  torus_cell_vertex_generator_top #(
    .SEGMENTS(SEGMENTS), .SECTIONS(SECTIONS), .TRIG_BITS(TRIG_BITS)
  ) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .section_index(section_index), .segment_index(segment_index),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .corner(corner), .last_corner(last_corner), .bad_index(bad_index)
  );

  tcvg_checker #(
    .SEGMENTS(SEGMENTS), .SECTIONS(SECTIONS), .TRIG_BITS(TRIG_BITS)
  ) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .section_index(section_index), .segment_index(segment_index),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .corner(corner), .last_corner(last_corner), .bad_index(bad_index),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Random sender gap before a cell
  task automatic sender_gap();
    int n;
    if (idle_en && $urandom_range(3) == 0) begin
      n = $urandom_range(7, 1);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // One cell transaction; start stays high for a following cell
  task automatic send_cell(input int sec, input int seg);
    sender_gap();
    start         <= 1'b1;
    section_index <= sec[IDX_W-1:0];
    segment_index <= seg[IDX_W-1:0];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_random_cell();
    int sec;
    int seg;
    if ($urandom_range(99) < 85) begin
      sec = $urandom_range(SECTIONS - 1);
      seg = $urandom_range(SEGMENTS - 1);
    end else if ($urandom_range(1)) begin
      sec = $urandom_range(255, SECTIONS);
      seg = $urandom_range(255);
    end else begin
      sec = $urandom_range(255);
      seg = $urandom_range(255, SEGMENTS);
    end
    send_cell(sec, seg);
  endtask

  // Stop sending and wait for every queued corner plus pipeline slack
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Register write transaction; the caller lowers cfg_valid after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RAD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Both radii, plus a write to an unmapped index that must be ignored
  task automatic set_radii(input logic [RAD_W-1:0] minor, input logic [RAD_W-1:0] major,
                           input logic [CFG_IDX_W-1:0] junk_idx);
    write_reg(CFG_MINOR_RADIUS, minor);
    write_reg(junk_idx, RAD_W'($urandom));
    write_reg(CFG_MAJOR_RADIUS, major);
    cfg_valid <= 1'b0;
  endtask

  // Watchdog: ends the run if nothing moves for too long
  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || (cfg_valid && cfg_ready) || result_valid)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [RAD_W-1:0]     minor;
    logic [RAD_W-1:0]     major;
    logic [CFG_IDX_W-1:0] junk_idx;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed cells at reset radii: wraps, quadrant edges, out-of-range indexes
    send_cell(0, 0);
    send_cell(SECTIONS - 1, SEGMENTS - 1);
    send_cell(SECTIONS - 1, 0);
    send_cell(0, SEGMENTS - 1);
    send_cell(8, 10);
    send_cell(15, 20);
    send_cell(22, 30);
    send_cell(7, 9);
    send_cell(SECTIONS, 0);
    send_cell(0, SEGMENTS);
    send_cell(SECTIONS, SEGMENTS);
    send_cell(255, 255);
    send_cell(255, 0);
    send_cell(0, 255);
    send_cell(128, 5);
    send_cell(3, 4);
    drain();

    // Random cells over several radius settings, extremes first
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin minor = 16'd0;     major = 16'd0;     end
        1: begin minor = 16'hFFFF;  major = 16'hFFFF;  end
        2: begin minor = 16'hFFFF;  major = 16'd0;     end
        3: begin minor = 16'd0;     major = 16'hFFFF;  end
        4: begin minor = RAD_W'($urandom); major = RAD_W'($urandom); end
        default: begin minor = MINOR_RADIUS_RST; major = MAJOR_RADIUS_RST; end
      endcase
      junk_idx = (ph % 2 == 0) ? CFG_IDX_W'(2) : CFG_IDX_W'(3);
      set_radii(minor, major, junk_idx);
      for (int i = 0; i < CELLS_PER_PH; i++) begin
        // final phase runs back to back; elsewhere gaps come and go in stretches
        if (ph == NUM_PHASES - 1)
          idle_en = 1'b0;
        else if (i % 9 == 0)
          idle_en = $urandom_range(1);
        send_random_cell();
      end
      drain();
    end

    if (errors == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
